/* sv/ssb_pkg.sv */
// Shared types and constants of the scaled sprite pixel blitter.
package ssb_pkg;

	// Field widths fixed by the stream and register formats
	localparam int unsigned COORD_W = 16;
	localparam int unsigned SCALE_W = 4;
	localparam int unsigned SIDE_W  = 9;
	localparam int unsigned SRC_W   = 8;
	localparam int unsigned RGB_W   = 24;
	localparam int unsigned ALPHA_W = 8;

	localparam int unsigned S_TDATA_W = 48;
	localparam int unsigned M_TDATA_W = 64;

	// Configuration port
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;

	// Queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	// Register indexes (byte address divided by four)
	typedef enum logic [2:0] {
		REG_POS_X        = 3'd0,
		REG_POS_Y        = 3'd1,
		REG_SCALE        = 3'd2,
		REG_FRAME_WIDTH  = 3'd3,
		REG_FRAME_HEIGHT = 3'd4
	} reg_idx_t;

	// Register reset values
	localparam logic [COORD_W-1:0] POS_RST   = 16'd0;
	localparam logic [SCALE_W-1:0] SCALE_RST = 4'd1;
	localparam logic [SIDE_W-1:0]  SIDE_RST  = 9'd16;

	// Configuration seen by the front
	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [SCALE_W-1:0]        scale;
		logic [SIDE_W-1:0]         frame_width;
		logic [SIDE_W-1:0]         frame_height;
	} cfg_t;

	// One queued block: top-left corner, side length and pixel payload
	typedef struct packed {
		logic signed [COORD_W-1:0] base_x;
		logic signed [COORD_W-1:0] base_y;
		logic [SCALE_W-1:0]        scale;
		logic [RGB_W-1:0]          rgb;
		logic [ALPHA_W-1:0]        alpha;
	} job_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

/* sv/ssb_front.sv */
// Front: accepts source pixels, drops transparent ones and computes the block corner.
module ssb_front #(
	parameter int unsigned MAX_FRAME_SIDE = 256,
	parameter int unsigned MAX_SCALE      = 8
) (
	input  ssb_pkg::cfg_t                     cfg,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// src_col[7:0], src_row[15:8], pixel_rgb[39:16], pixel_alpha[47:40]
	input  logic [ssb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	input  ssb_pkg::qstat_t                   qstat,
	output logic                              push,
	output ssb_pkg::job_t                     push_job
);

	logic [ssb_pkg::SRC_W-1:0]    col;
	logic [ssb_pkg::SRC_W-1:0]    row;
	logic [ssb_pkg::RGB_W-1:0]    rgb;
	logic [ssb_pkg::ALPHA_W-1:0]  alpha;
	logic [ssb_pkg::SCALE_W-1:0]  s;
	logic [ssb_pkg::SIDE_W-1:0]   fw;
	logic [ssb_pkg::SIDE_W-1:0]   fh;
	logic [11:0]                  col_s;
	logic [11:0]                  row_s;
	logic [12:0]                  fw_s;
	logic [12:0]                  fh_s;
	logic [ssb_pkg::COORD_W-1:0]  off_x;
	logic [ssb_pkg::COORD_W-1:0]  off_y;

	assign col   = s_axis_tdata[7:0];
	assign row   = s_axis_tdata[15:8];
	assign rgb   = s_axis_tdata[39:16];
	assign alpha = s_axis_tdata[47:40];

	// Saturate scale and frame sides
	always_comb begin
		s  = cfg.scale;
		fw = cfg.frame_width;
		fh = cfg.frame_height;
		if (32'(cfg.scale) > MAX_SCALE) begin
			s = ssb_pkg::SCALE_W'(MAX_SCALE);
		end
		if (32'(cfg.frame_width) > MAX_FRAME_SIDE) begin
			fw = ssb_pkg::SIDE_W'(MAX_FRAME_SIDE);
		end
		if (32'(cfg.frame_height) > MAX_FRAME_SIDE) begin
			fh = ssb_pkg::SIDE_W'(MAX_FRAME_SIDE);
		end
	end

	// Scaled offsets and centering terms
	assign col_s = 12'(col) * 12'(s);
	assign row_s = 12'(row) * 12'(s);
	assign fw_s  = 13'(fw) * 13'(s);
	assign fh_s  = 13'(fh) * 13'(s);
	assign off_x = 16'(fw_s >> 1);
	assign off_y = 16'(fh_s >> 1) + 16'(fh);

	// Build the queue entry; coordinates wrap at 16 bits
	always_comb begin
		push_job.base_x = $unsigned(cfg.pos_x) + 16'(col_s) - off_x;
		push_job.base_y = $unsigned(cfg.pos_y) + 16'(row_s) - off_y;
		push_job.scale  = s;
		push_job.rgb    = rgb;
		push_job.alpha  = alpha;
	end

	// Accept whenever the queue has room; drop empty blocks
	assign s_axis_tready = !qstat.full;
	assign push = s_axis_tvalid && !qstat.full && (alpha != '0) && (s != '0);

endmodule

/* sv/ssb_fifo.sv */
// Short queue of pending blocks between front and back.
module ssb_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssb_pkg::job_t   push_job,
	input  logic            pop,
	output ssb_pkg::job_t   head_job,
	output ssb_pkg::qstat_t qstat
);

	ssb_pkg::job_t                 entry_q [ssb_pkg::QDEPTH];
	logic [ssb_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ssb_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ssb_pkg::QCNT_W-1:0]    count_q;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_job    = entry_q[rd_ptr_q];
	assign qstat.full  = (count_q == ssb_pkg::QCNT_W'(ssb_pkg::QDEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

/* sv/ssb_back.sv */
// Back: walks queued blocks row by row, one destination pixel per cycle when not stalled.
module ssb_back #(
	parameter int unsigned MAX_SCALE = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssb_pkg::job_t                 head_job,
	input  ssb_pkg::qstat_t               qstat,
	output logic                          pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// dest_x[15:0], dest_y[31:16], out_rgb[55:32], out_alpha[63:56]
	output logic [ssb_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tlast
);

	localparam int unsigned CNT_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

	logic [CNT_W-1:0]             sx_q;
	logic [CNT_W-1:0]             sy_q;
	logic                         out_valid_q;
	logic [ssb_pkg::COORD_W-1:0]  dest_x_q;
	logic [ssb_pkg::COORD_W-1:0]  dest_y_q;
	logic [ssb_pkg::RGB_W-1:0]    rgb_q;
	logic [ssb_pkg::ALPHA_W-1:0]  alpha_q;
	logic                         last_q;
	logic                         load;
	logic [ssb_pkg::SCALE_W-1:0]  last_idx;
	logic                         row_end;
	logic                         blk_end;

	// Load the output register when it is empty or being drained
	assign load     = !qstat.empty && (!out_valid_q || m_axis_tready);
	assign last_idx = head_job.scale - 1'b1;
	assign row_end  = (ssb_pkg::SCALE_W'(sx_q) == last_idx);
	assign blk_end  = row_end && (ssb_pkg::SCALE_W'(sy_q) == last_idx);
	assign pop      = load && blk_end;

	// Step through the block, sub-column inner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q        <= '0;
			sy_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (row_end) begin
					sx_q <= '0;
					sy_q <= blk_end ? '0 : sy_q + 1'b1;
				end else begin
					sx_q <= sx_q + 1'b1;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (load) begin
			dest_x_q <= $unsigned(head_job.base_x) + ssb_pkg::COORD_W'(sx_q);
			dest_y_q <= $unsigned(head_job.base_y) + ssb_pkg::COORD_W'(sy_q);
			rgb_q    <= head_job.rgb;
			alpha_q  <= head_job.alpha;
			last_q   <= blk_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {alpha_q, rgb_q, dest_y_q, dest_x_q};
	assign m_axis_tlast  = last_q;

endmodule

/* sv/scaled_sprite_pixel_blitter.sv */
// Top level of the scaled sprite pixel blitter: register file, front, queue and back.
//
// Each opaque source pixel (nonzero alpha) becomes a scale-by-scale block of destination
// pixels, sent row by row with tlast on the final one; transparent pixels, and any pixel
// while scale is zero, produce nothing. The output delivers one destination pixel per
// cycle while m_axis_tready is high and a block is queued, so an opaque pixel holds the
// output for its scale*scale pixels and a transparent one never enters the queue. A
// four-entry block queue lets the input run ahead of the output; the input stalls only
// while that queue is full. Registers (pos_x, pos_y, scale, frame_width, frame_height at
// byte addresses 0, 4, 8, 12, 16) should be written only while no pixel is in flight.
module scaled_sprite_pixel_blitter #(
	parameter int unsigned MAX_FRAME_SIDE = 256,
	parameter int unsigned MAX_SCALE      = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssb_pkg::PADDR_W-1:0]   paddr,
	input  logic [ssb_pkg::PDATA_W-1:0]   pwdata,
	output logic [ssb_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	// Source pixel stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// src_col[7:0], src_row[15:8], pixel_rgb[39:16], pixel_alpha[47:40]
	input  logic [ssb_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// Destination pixel stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// dest_x[15:0], dest_y[31:16], out_rgb[55:32], out_alpha[63:56]
	output logic [ssb_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tlast
);

	ssb_pkg::cfg_t   cfg_q;
	ssb_pkg::job_t   push_job;
	ssb_pkg::job_t   head_job;
	ssb_pkg::qstat_t qstat;
	logic            push;
	logic            pop;
	logic            wr_en;
	logic [2:0]      reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x        <= ssb_pkg::POS_RST;
			cfg_q.pos_y        <= ssb_pkg::POS_RST;
			cfg_q.scale        <= ssb_pkg::SCALE_RST;
			cfg_q.frame_width  <= ssb_pkg::SIDE_RST;
			cfg_q.frame_height <= ssb_pkg::SIDE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				ssb_pkg::REG_POS_X:        cfg_q.pos_x        <= pwdata[15:0];
				ssb_pkg::REG_POS_Y:        cfg_q.pos_y        <= pwdata[15:0];
				ssb_pkg::REG_SCALE:        cfg_q.scale        <= pwdata[3:0];
				ssb_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[8:0];
				ssb_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[8:0];
				default: begin
				end
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (reg_idx)
			ssb_pkg::REG_POS_X:        prdata = 32'($unsigned(cfg_q.pos_x));
			ssb_pkg::REG_POS_Y:        prdata = 32'($unsigned(cfg_q.pos_y));
			ssb_pkg::REG_SCALE:        prdata = 32'(cfg_q.scale);
			ssb_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_q.frame_width);
			ssb_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_q.frame_height);
			default:                   prdata = '0;
		endcase
	end

	ssb_front #(
		.MAX_FRAME_SIDE(MAX_FRAME_SIDE),
		.MAX_SCALE(MAX_SCALE)
	) u_front (
		.cfg(cfg_q),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.qstat(qstat),
		.push(push),
		.push_job(push_job)
	);

	ssb_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head_job(head_job),
		.qstat(qstat)
	);

	ssb_back #(
		.MAX_SCALE(MAX_SCALE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_job(head_job),
		.qstat(qstat),
		.pop(pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule
